// File: rtl/core/ntcts_pkg.sv
// ----------------------------------------------------------------------------
// ntcts_pkg: shared types and constants for the NTC temperature block
// Widths, curve tables, per-mode trip tables, microcode word and status types.
// ----------------------------------------------------------------------------
package ntcts_pkg;

  // Field widths.
  localparam int ADC_W  = 12;
  localparam int TEMP_W = 11;
  localparam int CPU_W  = 9;
  localparam int TRIP_W = 8;
  localparam int MODE_W = 2;

  // Divider: numerator adc*100000 needs 29 bits, divisor 4096-adc needs 13.
  localparam int NUM_W  = 29;
  localparam int DEN_W  = 13;
  localparam int RES_W  = 21;
  localparam int IDX_W  = 5;
  localparam int DIFF_W = 19;
  localparam int SLP_W  = 7;
  localparam int MAG_W  = SLP_W + DIFF_W;
  localparam int UPC_W  = 3;

  localparam int ADC_FULL  = 4096;
  localparam int RES_SCALE = 100000;

  // Number of segments; the last curve point only closes the final segment.
  localparam logic [IDX_W-1:0] NSEG = IDX_W'(17);

  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 11'sd65;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -11'sd30;
  localparam logic signed [TEMP_W-1:0] TEMP_BAD  = -11'sd1000;

  // Power modes: normal, and benchmark as the reset value.
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BENCH  = 2'd3;

  // Byte address of the power mode register.
  localparam logic [1:0] MODE_REG_ADDR = 2'd0;

  // Trend codes.
  localparam logic [1:0] TREND_DROP   = 2'd0;
  localparam logic [1:0] TREND_STABLE = 2'd1;
  localparam logic [1:0] TREND_RISE   = 2'd2;

  // Micro-operations of the datapath.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_START,
    OP_DIV_GO,
    OP_RANGE,
    OP_SCAN,
    OP_MUL,
    OP_SCALE,
    OP_EMIT
  } op_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    C_NONE,
    C_FAST,
    C_DIV_BUSY,
    C_OUT_RANGE,
    C_SCAN_MORE,
    C_OUT_FULL
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  last;
  } uword_t;

  typedef struct packed {
    logic fast;
    logic div_busy;
    logic out_range;
    logic scan_more;
    logic out_full;
  } ustat_t;

  // Curve resistance points in ohms.
  function automatic logic [RES_W-1:0] curve_res(input logic [IDX_W-1:0] i);
    logic [RES_W-1:0] v;
    case (i)
      5'd0:    v = 21'd22220;
      5'd1:    v = 21'd27090;
      5'd2:    v = 21'd33190;
      5'd3:    v = 21'd40900;
      5'd4:    v = 21'd50680;
      5'd5:    v = 21'd63180;
      5'd6:    v = 21'd79230;
      5'd7:    v = 21'd100000;
      5'd8:    v = 21'd127000;
      5'd9:    v = 21'd162500;
      5'd10:   v = 21'd209400;
      5'd11:   v = 21'd271800;
      5'd12:   v = 21'd355600;
      5'd13:   v = 21'd469100;
      5'd14:   v = 21'd624100;
      5'd15:   v = 21'd837800;
      5'd16:   v = 21'd1135000;
      5'd17:   v = 21'd1154000;
      default: v = 21'd1154000;
    endcase
    return v;
  endfunction

  // Curve temperature points in degrees C.
  function automatic logic signed [6:0] curve_temp(input logic [IDX_W-1:0] i);
    logic signed [6:0] v;
    case (i)
      5'd0:    v = 7'sd60;
      5'd1:    v = 7'sd55;
      5'd2:    v = 7'sd50;
      5'd3:    v = 7'sd45;
      5'd4:    v = 7'sd40;
      5'd5:    v = 7'sd35;
      5'd6:    v = 7'sd30;
      5'd7:    v = 7'sd25;
      5'd8:    v = 7'sd20;
      5'd9:    v = 7'sd15;
      5'd10:   v = 7'sd10;
      5'd11:   v = 7'sd5;
      5'd12:   v = 7'sd0;
      5'd13:   v = -7'sd5;
      5'd14:   v = -7'sd10;
      5'd15:   v = -7'sd15;
      5'd16:   v = -7'sd20;
      default: v = -7'sd25;
    endcase
    return v;
  endfunction

  // Slope magnitudes; every slope of the curve is zero or negative.
  function automatic logic [SLP_W-1:0] curve_slope(input logic [IDX_W-1:0] i);
    logic [SLP_W-1:0] v;
    case (i)
      5'd0:    v = 7'd102;
      5'd1:    v = 7'd81;
      5'd2:    v = 7'd64;
      5'd3:    v = 7'd51;
      5'd4:    v = 7'd40;
      5'd5:    v = 7'd31;
      5'd6:    v = 7'd24;
      5'd7:    v = 7'd18;
      5'd8:    v = 7'd14;
      5'd9:    v = 7'd10;
      5'd10:   v = 7'd8;
      5'd11:   v = 7'd5;
      5'd12:   v = 7'd4;
      5'd13:   v = 7'd3;
      5'd14:   v = 7'd2;
      5'd15:   v = 7'd1;
      5'd16:   v = 7'd26;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // Per-mode trip points and CPU offset.
  function automatic logic [5:0] trip0_of(input logic [MODE_W-1:0] m);
    logic [5:0] v;
    case (m)
      2'd3:    v = 6'd30;
      default: v = 6'd38;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] trip1_of(input logic [MODE_W-1:0] m);
    logic [5:0] v;
    case (m)
      2'd0:    v = 6'd40;
      2'd1:    v = 6'd43;
      2'd2:    v = 6'd46;
      default: v = 6'd50;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] offset_of(input logic [MODE_W-1:0] m);
    logic [5:0] v;
    case (m)
      2'd3:    v = 6'd0;
      default: v = 6'd5;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/ntcts_div.sv
// ----------------------------------------------------------------------------
// ntcts_div: restoring unsigned divider
// Produces one quotient bit per cycle; the quotient is valid once busy falls.
// ----------------------------------------------------------------------------
module ntcts_div
  import ntcts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next numerator bit and try to subtract.
  always_comb begin
    trial = {rem_r, nq_r[NUM_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_comb begin
    nq_nxt   = nq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      nq_nxt   = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      nq_nxt   = {nq_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign quot = nq_r;

endmodule

// File: rtl/core/ntcts_seq.sv
// ----------------------------------------------------------------------------
// ntcts_seq: microcode sequencer
// Steps through a small control store and issues one control word per cycle.
// ----------------------------------------------------------------------------
module ntcts_seq
  import ntcts_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  ustat_t stat,
  output logic   busy,
  output uword_t ctrl
);

  localparam upc_t UP_START = 3'd0;
  localparam upc_t UP_DIVGO = 3'd1;
  localparam upc_t UP_DIVWT = 3'd2;
  localparam upc_t UP_RANGE = 3'd3;
  localparam upc_t UP_SCAN  = 3'd4;
  localparam upc_t UP_MUL   = 3'd5;
  localparam upc_t UP_SCALE = 3'd6;
  localparam upc_t UP_EMIT  = 3'd7;

  localparam uword_t IDLE_WORD = '{op: OP_NOP, cond: C_NONE, target: UP_START, last: 1'b0};

  // Control store. Fast cases jump straight to the emit step.
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = IDLE_WORD;
    case (pc)
      UP_START: w = '{op: OP_START,  cond: C_FAST,      target: UP_EMIT,  last: 1'b0};
      UP_DIVGO: w = '{op: OP_DIV_GO, cond: C_NONE,      target: UP_START, last: 1'b0};
      UP_DIVWT: w = '{op: OP_NOP,    cond: C_DIV_BUSY,  target: UP_DIVWT, last: 1'b0};
      UP_RANGE: w = '{op: OP_RANGE,  cond: C_OUT_RANGE, target: UP_EMIT,  last: 1'b0};
      UP_SCAN:  w = '{op: OP_SCAN,   cond: C_SCAN_MORE, target: UP_SCAN,  last: 1'b0};
      UP_MUL:   w = '{op: OP_MUL,    cond: C_NONE,      target: UP_START, last: 1'b0};
      UP_SCALE: w = '{op: OP_SCALE,  cond: C_NONE,      target: UP_START, last: 1'b0};
      UP_EMIT:  w = '{op: OP_EMIT,   cond: C_OUT_FULL,  target: UP_EMIT,  last: 1'b1};
      default:  w = IDLE_WORD;
    endcase
    return w;
  endfunction

  upc_t   upc_r, upc_nxt;
  logic   busy_r, busy_nxt;
  uword_t word;
  logic   take;

  assign word = ucode(upc_r);

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (word.cond)
      C_NONE:      take = 1'b0;
      C_FAST:      take = stat.fast;
      C_DIV_BUSY:  take = stat.div_busy;
      C_OUT_RANGE: take = stat.out_range;
      C_SCAN_MORE: take = stat.scan_more;
      C_OUT_FULL:  take = stat.out_full;
      default:     take = 1'b0;
    endcase
  end

  // Next step counter.
  always_comb begin
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = UP_START;
      end
    end else if (word.last && !take) begin
      busy_nxt = 1'b0;
      upc_nxt  = UP_START;
    end else if (take) begin
      upc_nxt = word.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UP_START;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign busy = busy_r;
  assign ctrl = busy_r ? word : IDLE_WORD;

endmodule

// File: rtl/core/ntcts_dp.sv
// ----------------------------------------------------------------------------
// ntcts_dp: datapath of the NTC temperature block
// Holds the word being worked on, the thermal state and the output register,
// and carries out the micro-operations issued by the sequencer.
// ----------------------------------------------------------------------------
module ntcts_dp
  import ntcts_pkg::*;
#(
  parameter int READ_HOLD = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     in_command,
  input  logic [ADC_W-1:0]         in_adc_value,
  input  logic                     in_adc_valid,
  input  logic signed [TEMP_W-1:0] in_ntc_reading,
  input  logic signed [CPU_W-1:0]  in_cpu_reading,
  input  logic [TRIP_W-1:0]        in_cpu_trip,
  input  logic [MODE_W-1:0]        mode,
  input  uword_t                   ctrl,
  output ustat_t                   stat,
  output logic                     div_start,
  output logic [NUM_W-1:0]         div_num,
  output logic [DEN_W-1:0]         div_den,
  input  logic                     div_busy,
  input  logic [NUM_W-1:0]         div_quot,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic [1:0]               out_trend,
  output logic                     out_cpu_hot
);

  localparam int CNT_W = $clog2(READ_HOLD + 1);
  localparam int SCALE_STEPS = 5;
  localparam logic [NUM_W-1:0] RES_SCALE_N = NUM_W'(RES_SCALE);

  // Captured word.
  logic                     cmd_r;
  logic [ADC_W-1:0]         adc_r;
  logic                     adc_ok_r;
  logic signed [TEMP_W-1:0] ntc_r;
  logic signed [CPU_W-1:0]  cpu_r;
  logic [TRIP_W-1:0]        trip_r;

  // Thermal state.
  logic signed [TEMP_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0]         rc_r, rc_nxt;
  logic                     hot_r, hot_nxt;

  // Working registers.
  logic signed [TEMP_W-1:0] result_r, result_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;

  // Output register.
  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic [1:0]               out_trend_r;
  logic                     out_hot_r;

  logic [CNT_W:0]           n_cnt;
  logic                     hit;
  logic signed [11:0]       ntc_s, cpu_s, trip_s, t0_s, off_s;
  logic                     hot_set, hot_clr, sel_ntc;
  logic signed [TEMP_W-1:0] sel_temp;
  logic                     r_lo, r_hi;
  logic [NUM_W-1:0]         seg_diff;
  logic [2:0]               q;
  logic signed [6:0]        seg_temp;
  logic signed [TEMP_W-1:0] trip1_s;
  logic [1:0]               trend;
  logic                     emit;

  // Read counter against the hold limit.
  always_comb begin
    n_cnt = {1'b0, rc_r} + 1'b1;
    hit   = (held_r != TEMP_BAD) && (n_cnt <= (CNT_W + 1)'(READ_HOLD));
    if (hit || n_cnt <= (CNT_W + 1)'(READ_HOLD)) begin
      rc_nxt = n_cnt[CNT_W-1:0];
    end else begin
      rc_nxt = '0;
    end
  end

  // Policy update: hysteresis on the hot flag and source selection.
  always_comb begin
    ntc_s   = {ntc_r[TEMP_W-1], ntc_r};
    cpu_s   = {{(12 - CPU_W){cpu_r[CPU_W-1]}}, cpu_r};
    trip_s  = {{(12 - TRIP_W){1'b0}}, trip_r};
    t0_s    = {6'b0, trip0_of(mode)};
    off_s   = {6'b0, offset_of(mode)};
    hot_set = (cpu_s >= trip_s - 12'sd1) && (ntc_s >= t0_s);
    hot_clr = (cpu_s <= trip_s - 12'sd2) || (ntc_s < t0_s - 12'sd1);
    if (mode == MODE_NORMAL) begin
      hot_nxt = (hot_r | hot_set) & ~hot_clr;
    end else begin
      hot_nxt = 1'b0;
    end
    sel_ntc  = (ntc_r != TEMP_BAD) && (ntc_s < t0_s) && (cpu_s < trip_s + off_s);
    sel_temp = sel_ntc ? ntc_r : {{(TEMP_W - CPU_W){cpu_r[CPU_W-1]}}, cpu_r};
  end

  // Resistance from the divider, range checks and segment arithmetic.
  always_comb begin
    r_lo     = div_quot < NUM_W'(curve_res('0));
    r_hi     = div_quot > NUM_W'(curve_res(NSEG));
    seg_diff = div_quot - NUM_W'(curve_res(idx_r));
    q        = '0;
    for (int j = 1; j <= SCALE_STEPS; j++) begin
      if (mag_r >= MAG_W'(j * RES_SCALE)) begin
        q = q + 3'd1;
      end
    end
  end

  // Temperature at the start of the selected segment.
  assign seg_temp = curve_temp(idx_r);

  // Divider request: numerator adc*100000, divisor 4096-adc.
  assign div_start = (ctrl.op == OP_DIV_GO);
  assign div_num   = NUM_W'(adc_r) * RES_SCALE_N;
  assign div_den   = DEN_W'(ADC_FULL) - DEN_W'(adc_r);

  // Status flags for the sequencer.
  always_comb begin
    stat.fast      = cmd_r | hit | ~adc_ok_r;
    stat.div_busy  = div_busy;
    stat.out_range = r_lo | r_hi;
    stat.scan_more = div_quot > NUM_W'(curve_res(idx_r + 1'b1));
    stat.out_full  = out_valid_r & out_stall;
  end

  assign emit = (ctrl.op == OP_EMIT) && !stat.out_full;

  // Trend of the held temperature against the mode's upper trip.
  always_comb begin
    trip1_s = {5'b0, trip1_of(mode)};
    if (held_r > trip1_s) begin
      trend = TREND_RISE;
    end else if (held_r < trip1_s) begin
      trend = TREND_DROP;
    end else begin
      trend = TREND_STABLE;
    end
  end

  // Micro-operation decode.
  always_comb begin
    held_nxt   = held_r;
    result_nxt = result_r;
    idx_nxt    = idx_r;
    mag_nxt    = mag_r;
    case (ctrl.op)
      OP_START: begin
        if (cmd_r) begin
          held_nxt   = ntc_r;
          result_nxt = sel_temp;
        end else if (hit) begin
          result_nxt = held_r;
        end else begin
          result_nxt = TEMP_BAD;
        end
      end
      OP_RANGE: begin
        idx_nxt    = '0;
        result_nxt = r_lo ? TEMP_HIGH : TEMP_LOW;
      end
      OP_SCAN: begin
        if (stat.scan_more) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      OP_MUL: begin
        mag_nxt = MAG_W'(curve_slope(idx_r)) * MAG_W'(seg_diff[DIFF_W-1:0]);
      end
      OP_SCALE: begin
        result_nxt = {{(TEMP_W - 7){seg_temp[6]}}, seg_temp}
                     - {{(TEMP_W - 3){1'b0}}, q};
      end
      default: begin
      end
    endcase
  end

  // Capture the input word.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      adc_r    <= in_adc_value;
      adc_ok_r <= in_adc_valid;
      ntc_r    <= in_ntc_reading;
      cpu_r    <= in_cpu_reading;
      trip_r   <= in_cpu_trip;
    end
  end

  // Thermal state and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= TEMP_BAD;
      rc_r        <= '0;
      hot_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      if (ctrl.op == OP_START) begin
        if (cmd_r) begin
          hot_r <= hot_nxt;
        end else begin
          rc_r <= rc_nxt;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    idx_r    <= idx_nxt;
    mag_r    <= mag_nxt;
    if (emit) begin
      out_temp_r  <= result_r;
      out_trend_r <= trend;
      out_hot_r   <= hot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_trend       = out_trend_r;
  assign out_cpu_hot     = out_hot_r;

endmodule

// File: rtl/core/ntc_temperature_and_thermal_select.sv
// ----------------------------------------------------------------------------
// ntc_temperature_and_thermal_select: NTC conversion and thermal source select
// A word with command 1 (policy update), a held-temperature reuse or an ADC
// that is not ready goes from the start step straight to the emit step. A
// full conversion runs the one-bit-per-cycle restoring divider that finds the
// resistance, then the range check, the linear scan over the curve segments,
// the slope multiply, scaling and result load. A conversion whose resistance
// falls outside the curve skips the scan, multiply and scaling. One word is
// worked on at a time; the next word can be taken on the cycle after the
// result is loaded, even while that result still waits on out_stall. The user
// must write the power mode register through the APB port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ntc_temperature_and_thermal_select
  import ntcts_pkg::*;
#(
  parameter int READ_HOLD = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic [ADC_W-1:0]         in_adc_value,
  input  logic                     in_adc_valid,
  input  logic signed [TEMP_W-1:0] in_ntc_reading,
  input  logic signed [CPU_W-1:0]  in_cpu_reading,
  input  logic [TRIP_W-1:0]        in_cpu_trip,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic [1:0]               out_trend,
  output logic                     out_cpu_hot,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic              busy;
  logic              accept;
  uword_t            ctrl;
  ustat_t            stat;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_busy;
  logic [NUM_W-1:0]  div_quot;
  logic [MODE_W-1:0] mode_r;

  // Configuration register; a single word, so the byte offset is ignored on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BENCH;
    end else if (psel && penable && pwrite && pready) begin
      mode_r <= pwdata[MODE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == MODE_REG_ADDR) ? {{(32 - MODE_W){1'b0}}, mode_r} : 32'd0;

  // Input handshake: one word in flight.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  ntcts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  ntcts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  ntcts_dp #(
    .READ_HOLD (READ_HOLD)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_command      (in_command),
    .in_adc_value    (in_adc_value),
    .in_adc_valid    (in_adc_valid),
    .in_ntc_reading  (in_ntc_reading),
    .in_cpu_reading  (in_cpu_reading),
    .in_cpu_trip     (in_cpu_trip),
    .mode            (mode_r),
    .ctrl            (ctrl),
    .stat            (stat),
    .div_start       (div_start),
    .div_num         (div_num),
    .div_den         (div_den),
    .div_busy        (div_busy),
    .div_quot        (div_quot),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_temperature (out_temperature),
    .out_trend       (out_trend),
    .out_cpu_hot     (out_cpu_hot)
  );

endmodule

// File: rtl/core/ntcts_chk.sv
// ----------------------------------------------------------------------------
// ntcts_chk: port-level checks for the NTC temperature block
// Watches the handshakes and result codes and is bound to the top level.
// ----------------------------------------------------------------------------
module ntcts_chk
  import ntcts_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [TEMP_W-1:0] out_temperature,
  input logic [1:0]               out_trend,
  input logic                     out_cpu_hot
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature)
      && $stable(out_trend) && $stable(out_cpu_hot))
    else $error("result word changed while stalled");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // An accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a word");

  // A new result only appears at the end of work on a word.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in flight");

  // Trend carries one of its three codes.
  a_trend_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_trend == TREND_DROP || out_trend == TREND_STABLE
      || out_trend == TREND_RISE))
    else $error("undefined trend code");

endmodule

bind ntc_temperature_and_thermal_select ntcts_chk u_ntcts_chk (.*);
